@@ hdl/assert_macros.svh @@
// Assertion macros for the bus decoder RTL.
// No dependencies; expects clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define CCBD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Same-cycle implication outside reset.
`define CCBD_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
`else
`define CCBD_ASSERT(lbl, prop, msg)
`define CCBD_ASSERT_IMPL(lbl, pre, post, msg)
`endif

`endif

@@ hdl/ccbd_pkg.sv @@
// Package for the CPU bus decoder: address map constants and target codes.
// No dependencies.
`default_nettype none

package ccbd_pkg;

	localparam int DEF_RAM_BYTES = 2048;     // 0x07FF + 1, the stock work RAM size
	localparam int MIRROR_SPAN   = 8192;     // size of the mirrored RAM window

	localparam logic [15:0] RAM_TOP         = 16'h1FFF;
	localparam logic [15:0] RAM_MIRROR_MASK = 16'h1FFF;
	localparam logic [15:0] VIDEO_BASE      = 16'h2000;
	localparam logic [15:0] VIDEO_TOP       = 16'h3FFF;
	localparam logic [15:0] VIDEO_FOLD      = 16'h2007;
	localparam logic [15:0] IO_BASE         = 16'h4000;
	localparam logic [15:0] PAD_BASE        = 16'h4016;
	localparam logic [15:0] PAD_TOP         = 16'h4017;
	localparam logic [15:0] TEST_BASE       = 16'h4018;
	localparam logic [15:0] TEST_TOP        = 16'h401F;
	localparam logic [15:0] IO_MASK         = 16'h001F;
	localparam logic [15:0] TEST_MASK       = 16'h0007;

	localparam int IO_DEPTH   = 32;
	localparam int TEST_DEPTH = 8;

	localparam logic [2:0] UNIT_RAM   = 3'd0;
	localparam logic [2:0] UNIT_VIDEO = 3'd1;
	localparam logic [2:0] UNIT_IO    = 3'd2;
	localparam logic [2:0] UNIT_PAD   = 3'd3;
	localparam logic [2:0] UNIT_TEST  = 3'd4;
	localparam logic [2:0] UNIT_CART  = 3'd5;

	localparam logic FUNC_WRITE = 1'b1;

endpackage

`default_nettype wire

@@ hdl/console_cpu_bus_decoder_core.sv @@
// CPU bus decoder top level: address decode, work RAM, I/O, test and pad registers.
// Depends on ccbd_pkg and assert_macros.svh.
//
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+-------------------------------------------
// in      | input     | in_valid / in_ready | func, bus_address, write_data, pad buttons
// out     | output    | out_valid/out_ready | read_data, target_unit, forward_address
//
// One request per cycle while the output is taken; an accepted request is registered in _s1, then in _q.
// Input register (_s1) feeds one decode pass; the result register (_q) and the
// work RAM's registered read port hold the answer. Stores update in request order.
// After reset the work RAM is cleared by a pass over all RAM_BYTES entries (one entry a
// cycle); in_ready stays low until it ends. I/O, test and pad registers reset at once.
// A stalled output holds its result while one more request waits in _s1; in_ready
// drops only when both are full and the output is not taken, or while the RAM clears.
`default_nettype none

`include "assert_macros.svh"

module console_cpu_bus_decoder_core #(
	parameter int RAM_BYTES = ccbd_pkg::DEF_RAM_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        func,
	input  wire logic [15:0] bus_address,
	input  wire logic [7:0]  write_data,
	input  wire logic [7:0]  pad_one_buttons,
	input  wire logic [7:0]  pad_two_buttons,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       read_data,
	output logic [2:0]       target_unit,
	output logic [15:0]      forward_address
);
	import ccbd_pkg::*;

	localparam int ADDR_W    = $clog2(RAM_BYTES);
	localparam int MOD_STEPS = (MIRROR_SPAN + RAM_BYTES - 1) / RAM_BYTES - 1;
	localparam logic [13:0] RAM_LIM = 14'(RAM_BYTES);
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(RAM_BYTES - 1);

	// Input register
	logic        valid_s1;
	logic        func_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wdata_s1;
	logic [7:0]  pad1_s1;
	logic [7:0]  pad2_s1;

	// Result register
	logic        out_valid_q;
	logic [7:0]  rd_q;
	logic [2:0]  unit_q;
	logic [15:0] fwd_q;
	logic        ram_sel_q;
	logic [7:0]  ram_rd_q;

	// Clearing pass
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// Stores
	logic [7:0] work_ram [RAM_BYTES];
	logic [7:0] io_q     [IO_DEPTH];
	logic [7:0] test_q   [TEST_DEPTH];
	logic [7:0] pad_q    [2];

	logic in_acc;
	logic adv;

	// Decode results
	logic [2:0]        unit_c;
	logic [15:0]       fwd_c;
	logic [7:0]        rd_c;
	logic [13:0]       mod_c;
	logic [ADDR_W-1:0] ram_idx;
	logic [4:0]        io_idx;
	logic [2:0]        test_idx;
	logic              pad_k;
	logic              is_wr;

	// Output targets that get an address instead of data
	logic fwd_tgt;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !clearing_q && (!valid_s1 || adv);
	assign in_acc   = in_valid && in_ready;

	assign is_wr    = (func_s1 == FUNC_WRITE);
	assign io_idx   = 5'(addr_s1 & IO_MASK);
	assign test_idx = 3'(addr_s1 & TEST_MASK);
	assign pad_k    = addr_s1[0];   // 0x4016 is even: pad one, 0x4017 pad two

	// RAM mirroring: (addr & 0x1FFF) mod RAM_BYTES; the result stays below RAM_BYTES
	always_comb begin
		mod_c = {1'b0, 13'(addr_s1 & RAM_MIRROR_MASK)};
		for (int i = 0; i < MOD_STEPS; i++) begin
			if (mod_c >= RAM_LIM) begin
				mod_c = mod_c - RAM_LIM;
			end
		end
	end
	assign ram_idx = mod_c[ADDR_W-1:0];

	always_comb begin
		unit_c = UNIT_CART;
		fwd_c  = addr_s1;
		rd_c   = '0;
		if (addr_s1 inside {[16'h0000 : RAM_TOP]}) begin
			unit_c = UNIT_RAM;
			fwd_c  = '0;
		end else if (addr_s1 inside {[VIDEO_BASE : VIDEO_TOP]}) begin
			unit_c = UNIT_VIDEO;
			fwd_c  = addr_s1 & VIDEO_FOLD;
		end else if (addr_s1 inside {[PAD_BASE : PAD_TOP]}) begin
			unit_c = UNIT_PAD;
			fwd_c  = '0;
			if (!is_wr) begin
				rd_c = {7'b0, pad_q[pad_k][0]};
			end
		end else if (addr_s1 inside {[IO_BASE : PAD_TOP]}) begin
			unit_c = UNIT_IO;
			fwd_c  = '0;
			if (!is_wr) begin
				rd_c = io_q[io_idx];
			end
		end else if (addr_s1 inside {[TEST_BASE : TEST_TOP]}) begin
			unit_c = UNIT_TEST;
			fwd_c  = '0;
			if (!is_wr) begin
				rd_c = test_q[test_idx];
			end
		end
	end

	// Control, register files and pad shifters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			for (int i = 0; i < IO_DEPTH; i++) begin
				io_q[i] <= '0;
			end
			for (int i = 0; i < TEST_DEPTH; i++) begin
				test_q[i] <= '0;
			end
			pad_q[0] <= '0;
			pad_q[1] <= '0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == CLR_LAST) begin
					clearing_q <= 1'b0;
				end
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				case (unit_c)
					UNIT_IO: begin
						if (is_wr) begin
							io_q[io_idx] <= wdata_s1;
						end
					end
					UNIT_PAD: begin
						if (is_wr) begin
							// strobe write: store the byte in io_q and latch both pads whatever its value
							io_q[io_idx] <= wdata_s1;
							pad_q[0]     <= pad1_s1;
							pad_q[1]     <= pad2_s1;
						end else begin
							pad_q[pad_k] <= {1'b0, pad_q[pad_k][7:1]};
						end
					end
					UNIT_TEST: begin
						if (is_wr) begin
							test_q[test_idx] <= wdata_s1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1  <= func;
			addr_s1  <= bus_address;
			wdata_s1 <= write_data;
			pad1_s1  <= pad_one_buttons;
			pad2_s1  <= pad_two_buttons;
		end
		if (adv) begin
			rd_q      <= rd_c;
			unit_q    <= unit_c;
			fwd_q     <= fwd_c;
			ram_sel_q <= (unit_c == UNIT_RAM) && !is_wr;
		end
	end

	// Work RAM: one write port shared with the clearing pass, one registered read
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			work_ram[clr_addr_q] <= '0;
		end else if (adv && unit_c == UNIT_RAM && is_wr) begin
			work_ram[ram_idx] <= wdata_s1;
		end
		if (adv && unit_c == UNIT_RAM && !is_wr) begin
			ram_rd_q <= work_ram[ram_idx];
		end
	end

	assign out_valid       = out_valid_q;
	assign read_data       = ram_sel_q ? ram_rd_q : rd_q;
	assign target_unit     = unit_q;
	assign forward_address = fwd_q;

	assign fwd_tgt = (target_unit == UNIT_VIDEO) || (target_unit == UNIT_CART);

	// Nothing sits in the input register while the RAM is still being cleared
	`CCBD_ASSERT_IMPL(a_no_work_in_clear, clearing_q, !valid_s1, "request held during RAM clear")
	// Internal targets never forward an address
	`CCBD_ASSERT_IMPL(a_fwd_zero, out_valid && !fwd_tgt, fwd_q == '0, "internal target forwards")
	// Forwarded targets return no data of their own
	`CCBD_ASSERT_IMPL(a_rd_zero_fwd, out_valid && fwd_tgt, read_data == '0, "data on forwarded target")
	// Pad port reads yield a single bit
	`CCBD_ASSERT_IMPL(a_pad_one_bit, out_valid && unit_q == UNIT_PAD, read_data[7:1] == '0, "wide pad read")

endmodule

`default_nettype wire
